// ----- rtl/core/dtpb_pkg.sv -----
// Shared types and constants for the depth-to-point back-projection unit.
`default_nettype none

package dtpb_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  typedef struct packed {
    logic       frame_start;
    logic [15:0] depth_mm;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        point_z;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
  } point_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [4:0]  sample_stride;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
  } cfg_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_SAMPLE_STRIDE = 3'd2,
    REG_INV_FOCAL_X   = 3'd3,
    REG_INV_FOCAL_Y   = 3'd4,
    REG_CENTER_X      = 3'd5,
    REG_CENTER_Y      = 3'd6
  } cfg_reg_t;

  localparam cfg_t CFG_RESET = '{
    frame_width:   13'd640,
    frame_height:  13'd480,
    sample_stride: 5'd3,
    inv_focal_x:   24'd29433,
    inv_focal_y:   24'd29433,
    center_x:      16'd5120,
    center_y:      16'd3840
  };

endpackage

`default_nettype wire

// ----- rtl/core/dtpb_fifo.sv -----
// Small register-based queue with occupancy count.
`default_nettype none

module dtpb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic [WIDTH-1:0]   wdata,
  output logic                    full,
  input  wire logic               pop,
  output logic [WIDTH-1:0]        rdata,
  output logic                    empty,
  output logic [$clog2(DEPTH):0]  count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push & ~full;
  assign pop_ok  = pop & ~empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) wr_ptr <= wr_ptr + AW'(1);
      if (pop_ok)  rd_ptr <= rd_ptr + AW'(1);
      if (push_ok && !pop_ok)      count <= count + (AW+1)'(1);
      else if (!push_ok && pop_ok) count <= count - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

// ----- rtl/core/dtpb_front.sv -----
// Front end: raster counters, stride phases and keep/drop decision per pixel.
`default_nettype none

module dtpb_front import dtpb_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int DEPTH_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cfg_t                        cfg,
  input  wire logic                        push,
  input  wire pixel_t                      pixel,
  output logic                             full,
  input  wire logic                        mid_full,
  output logic                             keep,
  output logic [$clog2(MAX_DIM)-1:0]       keep_col,
  output logic [$clog2(MAX_DIM)-1:0]       keep_row,
  output pixel_t                           keep_pixel
);

  localparam int CW  = $clog2(MAX_DIM);
  localparam int RBW = $clog2(CW);

  logic [CW-1:0]         column_count, row_count;
  logic [CW-1:0]         column_count_next, row_count_next;
  logic [CW-1:0]         u, v;
  logic [4:0]            col_phase, row_phase;
  logic [4:0]            col_phase_next, row_phase_next;
  logic [4:0]            cph, rph, cph_inc, rph_inc;
  logic [4:0]            stride_seen, stride_eff;
  logic                  stride_change;
  logic                  remap;
  logic [RBW-1:0]        rem_bit;
  logic [4:0]            rem_c, rem_r, rem_c_next, rem_r_next;
  logic [5:0]            trial_c, trial_r;
  logic [12:0]           w_clamp, h_clamp, w_m1, h_m1;
  logic [DEPTH_BITS-1:0] depth;
  logic                  accept;

  // stride in use is the one latched when the phases were last rebuilt
  assign stride_eff    = (stride_seen == '0) ? 5'd1 : stride_seen;
  assign stride_change = (cfg.sample_stride != stride_seen);
  assign full          = mid_full | remap | stride_change;
  assign accept        = push & ~full;

  assign w_clamp = (cfg.frame_width == '0) ? 13'd1 :
                   (cfg.frame_width > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg.frame_width;
  assign h_clamp = (cfg.frame_height == '0) ? 13'd1 :
                   (cfg.frame_height > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg.frame_height;
  assign w_m1    = w_clamp - 13'd1;
  assign h_m1    = h_clamp - 13'd1;

  assign u     = pixel.frame_start ? '0 : column_count;
  assign v     = pixel.frame_start ? '0 : row_count;
  assign cph   = pixel.frame_start ? '0 : col_phase;
  assign rph   = pixel.frame_start ? '0 : row_phase;
  assign depth = pixel.depth_mm[DEPTH_BITS-1:0];

  assign cph_inc = (cph + 5'd1 == stride_eff) ? '0 : cph + 5'd1;
  assign rph_inc = (rph + 5'd1 == stride_eff) ? '0 : rph + 5'd1;

  assign keep     = accept && (depth != '0) && (cph == '0) && (rph == '0);
  assign keep_col = u;
  assign keep_row = v;

  always_comb begin
    keep_pixel          = pixel;
    keep_pixel.depth_mm = 16'(depth);
  end

  always_comb begin
    row_count_next = v;
    row_phase_next = rph;
    if (13'(u) >= w_m1) begin
      column_count_next = '0;
      col_phase_next    = '0;
      if (13'(v) >= h_m1) begin
        row_count_next = '0;
        row_phase_next = '0;
      end else begin
        row_count_next = v + CW'(1);
        row_phase_next = rph_inc;
      end
    end else begin
      column_count_next = u + CW'(1);
      col_phase_next    = cph_inc;
    end
  end

  // shift-subtract remainder of both counters by the new stride, one bit a cycle
  assign trial_c    = {rem_c, column_count[rem_bit]};
  assign trial_r    = {rem_r, row_count[rem_bit]};
  assign rem_c_next = (trial_c >= {1'b0, stride_eff}) ? 5'(trial_c - {1'b0, stride_eff})
                                                       : trial_c[4:0];
  assign rem_r_next = (trial_r >= {1'b0, stride_eff}) ? 5'(trial_r - {1'b0, stride_eff})
                                                       : trial_r[4:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      col_phase    <= '0;
      row_phase    <= '0;
      stride_seen  <= CFG_RESET.sample_stride;
      remap        <= 1'b0;
      rem_bit      <= '0;
      rem_c        <= '0;
      rem_r        <= '0;
    end else if (remap) begin
      rem_c <= rem_c_next;
      rem_r <= rem_r_next;
      if (rem_bit == '0) begin
        col_phase <= rem_c_next;
        row_phase <= rem_r_next;
        remap     <= 1'b0;
      end else begin
        rem_bit <= rem_bit - RBW'(1);
      end
    end else if (stride_change) begin
      stride_seen <= cfg.sample_stride;
      remap       <= 1'b1;
      rem_bit     <= RBW'(CW - 1);
      rem_c       <= '0;
      rem_r       <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      col_phase    <= col_phase_next;
      row_phase    <= row_phase_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dtpb_back.sv -----
// Back end: offset, two chained multiplies, rounding/saturation, result queue.
`default_nettype none

module dtpb_back import dtpb_pkg::*; #(
  parameter int CW        = 12,
  parameter int OUT_DEPTH = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic          mid_empty,
  output logic               mid_pop,
  input  wire logic [CW-1:0] mid_col,
  input  wire logic [CW-1:0] mid_row,
  input  wire pixel_t        mid_pixel,
  output logic               empty,
  input  wire logic          pop,
  output point_t             point
);

  localparam int OCW = $clog2(OUT_DEPTH) + 1;
  localparam int SUW = OCW + 1;

  logic [15:0]    px, py;
  logic           neg_x, neg_y;

  logic           s0_valid, s1_valid, s2_valid;
  logic [15:0]    s0_off_x, s0_off_y, s0_depth;
  logic           s0_neg_x, s0_neg_y, s1_neg_x, s1_neg_y, s2_neg_x, s2_neg_y;
  logic [23:0]    s0_rgb, s1_rgb, s2_rgb;
  logic [15:0]    s1_depth, s2_depth;
  logic [31:0]    s1_od_x, s1_od_y;
  logic [55:0]    s2_mag_x, s2_mag_y;

  logic [1:0]     inflight;
  logic [OCW-1:0] out_count;
  point_t         result;

  function automatic logic [31:0] round_sat(input logic [55:0] mag, input logic neg);
    logic [56:0] sum;
    logic [32:0] q;
    logic [31:0] r;
    sum = {1'b0, mag} + (57'd1 << 23);
    q   = sum[56:24];
    if (neg) r = (q > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'd0 - q);
    else     r = (q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    return r;
  endfunction

  // issue only when the result queue has room for everything in flight
  assign inflight = 2'(s0_valid) + 2'(s1_valid) + 2'(s2_valid);
  assign mid_pop  = ~mid_empty &&
                    ((SUW'(out_count) + SUW'(inflight)) < SUW'(OUT_DEPTH));

  assign px    = 16'({mid_col, 4'b0000});
  assign py    = 16'({mid_row, 4'b0000});
  assign neg_x = px < cfg.center_x;
  assign neg_y = py < cfg.center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s0_valid <= mid_pop;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_off_x <= neg_x ? cfg.center_x - px : px - cfg.center_x;
    s0_off_y <= neg_y ? cfg.center_y - py : py - cfg.center_y;
    s0_neg_x <= neg_x;
    s0_neg_y <= neg_y;
    s0_depth <= mid_pixel.depth_mm;
    s0_rgb   <= {mid_pixel.red_in, mid_pixel.green_in, mid_pixel.blue_in};

    s1_od_x  <= 32'(s0_off_x) * 32'(s0_depth);
    s1_od_y  <= 32'(s0_off_y) * 32'(s0_depth);
    s1_neg_x <= s0_neg_x;
    s1_neg_y <= s0_neg_y;
    s1_depth <= s0_depth;
    s1_rgb   <= s0_rgb;

    s2_mag_x <= s1_od_x * cfg.inv_focal_x;
    s2_mag_y <= s1_od_y * cfg.inv_focal_y;
    s2_neg_x <= s1_neg_x;
    s2_neg_y <= s1_neg_y;
    s2_depth <= s1_depth;
    s2_rgb   <= s1_rgb;
  end

  always_comb begin
    result.point_x   = round_sat(s2_mag_x, s2_neg_x);
    result.point_y   = round_sat(s2_mag_y, s2_neg_y);
    result.point_z   = s2_depth;
    result.red_out   = s2_rgb[23:16];
    result.green_out = s2_rgb[15:8];
    result.blue_out  = s2_rgb[7:0];
  end

  dtpb_fifo #(
    .WIDTH ($bits(point_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (s2_valid),
    .wdata (result),
    .full  (),
    .pop   (pop),
    .rdata (point),
    .empty (empty),
    .count (out_count)
  );

endmodule

`default_nettype wire

// ----- rtl/core/depth_to_point_backprojection_unit.sv -----
// Top level: config registers, front end, middle queue and back end.
//
//   channel  dir  handshake      payload
//   pixel    in   push / full    pixel_t
//   point    out  pop / empty    point_t
//   config   in   cfg_we         cfg_addr, cfg_data
//
// One pixel is taken per cycle while full is low; the back end issues one item a
// cycle into its offset/multiply/multiply pipe while the middle queue holds items
// and the result queue has room, which sets the sustained rate. A kept pixel passes
// the middle queue, stages s0, s1, s2 and the result queue before it shows as a point.
// Reset (synchronous) clears counters, queues and loads the register defaults.
// A sample_stride write holds full high while the column and row phases are
// rebuilt; full also rises when the middle queue fills behind a stalled pop.
`default_nettype none

module depth_to_point_backprojection_unit import dtpb_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int DEPTH_BITS = 16,
  parameter int MID_DEPTH  = 4,
  parameter int OUT_DEPTH  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire pixel_t                pixel,
  output logic                       empty,
  input  wire logic                  pop,
  output point_t                     point,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int MID_W = 2 * CW + $bits(pixel_t);

  cfg_t             cfg;
  logic             mid_full, mid_empty, mid_pop;
  logic             keep;
  logic [CW-1:0]    keep_col, keep_row, mid_col, mid_row;
  pixel_t           keep_pixel, mid_pixel;
  logic [MID_W-1:0] mid_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[12:0];
        REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[12:0];
        REG_SAMPLE_STRIDE: cfg.sample_stride <= cfg_data[4:0];
        REG_INV_FOCAL_X:   cfg.inv_focal_x   <= cfg_data[23:0];
        REG_INV_FOCAL_Y:   cfg.inv_focal_y   <= cfg_data[23:0];
        REG_CENTER_X:      cfg.center_x      <= cfg_data[15:0];
        REG_CENTER_Y:      cfg.center_y      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  dtpb_front #(
    .MAX_DIM    (MAX_DIM),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .pixel      (pixel),
    .full       (full),
    .mid_full   (mid_full),
    .keep       (keep),
    .keep_col   (keep_col),
    .keep_row   (keep_row),
    .keep_pixel (keep_pixel)
  );

  dtpb_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (keep),
    .wdata ({keep_col, keep_row, keep_pixel}),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count ()
  );

  assign {mid_col, mid_row, mid_pixel} = mid_rdata;

  dtpb_back #(
    .CW        (CW),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_col   (mid_col),
    .mid_row   (mid_row),
    .mid_pixel (mid_pixel),
    .empty     (empty),
    .pop       (pop),
    .point     (point)
  );

endmodule

`default_nettype wire

// ----- rtl/core/dtpb_checker.sv -----
// Port-level checks on the back-projection unit, bound to the top level.
`default_nettype none

module dtpb_checker import dtpb_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   full,
  input wire logic   empty,
  input wire logic   pop,
  input wire point_t point
);

  // reset flushes both queues and loads a consistent stride
  a_reset_flush: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not flushed after reset");

  // only pixels with non-zero depth become points
  a_depth_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> point.point_z != 16'd0)
    else $error("point with zero depth");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(point))
    else $error("waiting point lost or changed");

endmodule

bind depth_to_point_backprojection_unit dtpb_checker u_dtpb_checker (.*);

`default_nettype wire

// ----- tb/sv/dtpb_point_checker.sv -----
// Point stream checker: predicts back-projected points from accepted pixels and compares.
module dtpb_point_checker import dtpb_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int DEPTH_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic                  full,
  input  wire pixel_t                pixel,
  input  wire logic                  empty,
  input  wire logic                  pop,
  input  wire point_t                point,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         errors,
  output int                         outstanding
);

  cfg_t        regs;
  logic [11:0] col;
  logic [11:0] row;
  point_t      points_due[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  // Q.4 offset times depth times Q0.24 reciprocal, rounded half away from zero, saturated
  function automatic logic [31:0] back_project(input logic [11:0] pos,
                                               input logic [15:0] centre,
                                               input logic [15:0] depth,
                                               input logic [23:0] inv);
    logic [15:0] scaled;
    logic        neg;
    logic [15:0] offset;
    logic [63:0] mag;
    logic [63:0] q;
    scaled = {pos, 4'b0000};
    neg    = scaled < centre;
    offset = neg ? centre - scaled : scaled - centre;
    mag    = 64'(offset) * 64'(depth) * 64'(inv);
    q      = (mag + 64'h80_0000) >> 24;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(64'd0 - q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  always @(posedge clk) begin : watch
    point_t      want;
    logic [15:0] depth;
    int          u;
    int          v;
    int          w;
    int          h;
    int          stride;
    if (rst) begin
      regs = CFG_RESET;
      col  = '0;
      row  = '0;
      points_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_FRAME_WIDTH:   regs.frame_width   = cfg_data[12:0];
          REG_FRAME_HEIGHT:  regs.frame_height  = cfg_data[12:0];
          REG_SAMPLE_STRIDE: regs.sample_stride = cfg_data[4:0];
          REG_INV_FOCAL_X:   regs.inv_focal_x   = cfg_data[23:0];
          REG_INV_FOCAL_Y:   regs.inv_focal_y   = cfg_data[23:0];
          REG_CENTER_X:      regs.center_x      = cfg_data[15:0];
          REG_CENTER_Y:      regs.center_y      = cfg_data[15:0];
          default: ;
        endcase
      end

      if (push && !full) begin
        depth  = pixel.depth_mm & 16'((32'd1 << DEPTH_BITS) - 1);
        stride = (regs.sample_stride == 0) ? 1 : int'(regs.sample_stride);
        w      = (regs.frame_width == 0) ? 1 :
                 (regs.frame_width > MAX_DIM) ? MAX_DIM : int'(regs.frame_width);
        h      = (regs.frame_height == 0) ? 1 :
                 (regs.frame_height > MAX_DIM) ? MAX_DIM : int'(regs.frame_height);
        if (pixel.frame_start) begin
          col = '0;
          row = '0;
        end
        u = int'(col);
        v = int'(row);
        if (depth != 0 && (u % stride) == 0 && (v % stride) == 0) begin
          want.point_x   = back_project(col, regs.center_x, depth, regs.inv_focal_x);
          want.point_y   = back_project(row, regs.center_y, depth, regs.inv_focal_y);
          want.point_z   = depth;
          want.red_out   = pixel.red_in;
          want.green_out = pixel.green_in;
          want.blue_out  = pixel.blue_in;
          points_due.insert(points_due.size(), want);
        end
        // a counter left past the edge by a smaller frame wraps at once
        if (u >= w - 1) begin
          col = '0;
          row = (v >= h - 1) ? 12'd0 : 12'(v + 1);
        end else begin
          col = 12'(u + 1);
        end
      end

      if (pop && !empty) begin
        if (points_due.size() == 0) begin
          errors++;
          $display("%0t: point with none expected: x=%0d y=%0d z=%0d rgb=%02h%02h%02h",
                   $time, point.point_x, point.point_y, point.point_z,
                   point.red_out, point.green_out, point.blue_out);
        end else begin
          want = points_due.pop_front();
          if (point !== want) begin
            errors++;
            $display("%0t: point mismatch: expected x=%0d y=%0d z=%0d rgb=%02h%02h%02h",
                     $time, want.point_x, want.point_y, want.point_z,
                     want.red_out, want.green_out, want.blue_out);
            $display("%0t:                 actual   x=%0d y=%0d z=%0d rgb=%02h%02h%02h",
                     $time, point.point_x, point.point_y, point.point_z,
                     point.red_out, point.green_out, point.blue_out);
          end
        end
      end
    end
    outstanding <= points_due.size();
  end

endmodule

// ----- tb/sv/tb_depth_to_point_backprojection_unit.sv -----
// Testbench top: pixel stimulus, point drain, register set-up and verdict.
module tb_depth_to_point_backprojection_unit;
  import dtpb_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int LIMIT_CYCLES = 250_000;

  typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_POP_STALLS, FLOW_BOTH} flow_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  push     = 1'b0;
  logic                  full;
  pixel_t                pixel    = '0;
  logic                  empty;
  logic                  pop      = 1'b0;
  point_t                point;
  logic                  cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors;
  int outstanding;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  bit hold_req      = 1'b0;

  depth_to_point_backprojection_unit uut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .pixel    (pixel),
    .empty    (empty),
    .pop      (pop),
    .point    (point),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  dtpb_point_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pixel       (pixel),
    .empty       (empty),
    .pop         (pop),
    .point       (point),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * LIMIT_CYCLES);
    $display("tb: failure");
    $finish;
  end

  // point drain; a hold request keeps pop low for a long counted stretch
  initial begin : drain
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  task automatic set_flow(input flow_t f);
    case (f)
      FLOW_FREE:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
      FLOW_SEND_GAPS:  begin send_idle_pct = 58; pop_stall_pct = 0;  end
      FLOW_POP_STALLS: begin send_idle_pct = 0;  pop_stall_pct = 58; end
      default:         begin send_idle_pct = 25; pop_stall_pct = 25; end
    endcase
  endtask

  // push stays high after acceptance so back-to-back items need no second assignment
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (full);
  endtask

  task automatic put_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_addr <= r;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic load_cfg(input cfg_t c);
    put_reg(REG_FRAME_WIDTH,   CFG_DATA_W'(c.frame_width));
    put_reg(REG_FRAME_HEIGHT,  CFG_DATA_W'(c.frame_height));
    put_reg(REG_SAMPLE_STRIDE, CFG_DATA_W'(c.sample_stride));
    put_reg(REG_INV_FOCAL_X,   CFG_DATA_W'(c.inv_focal_x));
    put_reg(REG_INV_FOCAL_Y,   CFG_DATA_W'(c.inv_focal_y));
    put_reg(REG_CENTER_X,      CFG_DATA_W'(c.center_x));
    put_reg(REG_CENTER_Y,      CFG_DATA_W'(c.center_y));
    cfg_we <= 1'b0;
  endtask

  // drained, then a margin before the next phase
  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
    repeat (12) @(posedge clk);
  endtask

  function automatic pixel_t make_pixel(input int max_pct);
    pixel_t p;
    int     r;
    p.frame_start = ($urandom_range(99) < 2);
    r = $urandom_range(99);
    if (r < 8)                p.depth_mm = 16'h0000;
    else if (r < 8 + max_pct) p.depth_mm = 16'hFFFF;
    else if (r < 12 + max_pct) p.depth_mm = 16'h0001;
    else                      p.depth_mm = 16'($urandom_range(1, 65535));
    p.red_in   = 8'($urandom);
    p.green_in = 8'($urandom);
    p.blue_in  = 8'($urandom);
    return p;
  endfunction

  function automatic logic [12:0] pick_dim(input int top);
    case ($urandom_range(9))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd4096;
      3:       return 13'd8191;
      default: return 13'($urandom_range(2, top));
    endcase
  endfunction

  function automatic logic [23:0] pick_inv();
    case ($urandom_range(5))
      0:       return 24'd0;
      1:       return 24'hFF_FFFF;
      2:       return 24'd29433;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_centre();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 16 * 48));
    endcase
  endfunction

  function automatic cfg_t pick_cfg();
    cfg_t c;
    c.frame_width  = pick_dim(48);
    c.frame_height = pick_dim(24);
    case ($urandom_range(9))
      0:       c.sample_stride = 5'd0;
      1:       c.sample_stride = 5'd31;
      2:       c.sample_stride = 5'd16;
      3:       c.sample_stride = 5'd1;
      default: c.sample_stride = 5'($urandom_range(1, 4));
    endcase
    c.inv_focal_x = pick_inv();
    c.inv_focal_y = pick_inv();
    c.center_x    = pick_centre();
    c.center_y    = pick_centre();
    return c;
  endfunction

  // resume: first item carries no frame start, so counters continue from the last phase
  task automatic run_phase(input cfg_t c, input flow_t f, input int n,
                           input bit resume, input int max_pct);
    pixel_t p;
    wait_drained();
    load_cfg(c);
    set_flow(f);
    for (int i = 0; i < n; i++) begin
      p = make_pixel(max_pct);
      if (i == 0) p.frame_start = !resume;
      send_pixel(p);
    end
    push <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] first_depths[5];
    cfg_t        c;
    first_depths = '{16'hFFFF, 16'h1234, 16'h5678, 16'h0000, 16'h0001};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: origin kept, zero depth at the next stride column dropped
    for (int i = 0; i < 5; i++)
      send_pixel('{(i == 0), first_depths[i], 8'hFF ^ 8'(i), 8'h00 | 8'(i), 8'hA5});
    push <= 1'b0;

    // deepest negative offsets, saturating x and a zero vertical reciprocal
    c = '{13'd3, 13'd2, 5'd1, 24'hFF_FFFF, 24'd0, 16'hFFFF, 16'h0000};
    run_phase(c, FLOW_FREE, 6, 1'b0, 60);
    // zero sizes and zero stride: every pixel lands on the origin
    c = '{13'd0, 13'd0, 5'd0, 24'd29433, 24'h80_0000, 16'd0, 16'hFFFF};
    run_phase(c, FLOW_FREE, 4, 1'b0, 30);
    // shrink the frame behind a running counter
    c = '{13'd64, 13'd64, 5'd1, 24'd100000, 24'd100000, 16'd160, 16'd160};
    run_phase(c, FLOW_FREE, 10, 1'b0, 10);
    c.frame_width  = 13'd5;
    c.frame_height = 13'd1;
    run_phase(c, FLOW_SEND_GAPS, 5, 1'b1, 10);

    for (int k = 0; k < 15; k++)
      run_phase(pick_cfg(), flow_t'(k % 4), 50, ($urandom_range(3) == 0), 10);

    // long drain hold-off while pixels keep coming, so the unit backs up
    wait_drained();
    hold_req = 1'b1;
    c = '{13'd16, 13'd16, 5'd1, 24'd29433, 24'd29433, 16'd128, 16'd128};
    run_phase(c, FLOW_FREE, 80, 1'b0, 10);

    // oversize width clamps to the widest frame, one row, large positive x
    c = '{13'd8191, 13'd0, 5'd16, 24'hFF_FFFF, 24'($urandom), 16'h0000, 16'hFFFF};
    run_phase(c, FLOW_FREE, 330, 1'b0, 60);

    for (int k = 0; k < 4; k++)
      run_phase(pick_cfg(), flow_t'(k), 40, 1'b0, 10);

    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dtpb_pkg.sv
rtl/core/dtpb_fifo.sv
rtl/core/dtpb_front.sv
rtl/core/dtpb_back.sv
rtl/core/depth_to_point_backprojection_unit.sv
rtl/core/dtpb_checker.sv
tb/sv/dtpb_point_checker.sv
tb/sv/tb_depth_to_point_backprojection_unit.sv
